>>> rtl/core/cqe_pkg.sv
// shared types, codes and defaults of the circular queue engine
package cqe_pkg;

  // default number of words held by the queue
  localparam int DEPTH_DEF = 8;

  // operation codes carried by an input transaction
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_DISP = 2'd3;

  // status codes carried by a result transaction
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // input transaction
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } cqe_in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } cqe_out_t;

endpackage

>>> rtl/core/circular_queue_engine.sv
// circular queue engine: a fifo of signed 32-bit words driven by commands
//
// A command transaction (in_item: func, value) is taken at a rising edge with
// start high and busy low. Every result transaction appears on out_item for
// exactly one cycle with out_valid high; the receiver cannot stall it.
// Enqueue, dequeue and peek give one result in the cycle after the command is
// taken, and busy stays low, so one such command can be taken every cycle.
// Display of n stored words gives n results in consecutive cycles, the first
// in the cycle after the command; busy is high while the words after the
// first are swept, since the storage has a single read port that is swept
// one word per cycle. An empty queue answers dequeue, peek and display with a
// single empty-status result. The last result of each command has last set.
// Reset (rst_n low, synchronous) empties the queue and clears any display in
// progress; stored words are not cleared, and no clearing pass is needed
// since only words that were written are ever read.
module circular_queue_engine #(
  parameter int DEPTH = cqe_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cqe_pkg::cqe_in_t  in_item,
  output logic              out_valid,
  output cqe_pkg::cqe_out_t out_item
);
  import cqe_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W:0] DEPTH_X = (IDX_W+1)'(DEPTH);

  // queue pointers and display sweep state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic             disp_r, disp_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] left_r, left_nxt;

  // result registers
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_mem_r, out_mem_nxt;

  // storage port signals
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_data;

  logic             accept;
  logic             full;
  logic [IDX_W:0]   span;
  logic [IDX_W-1:0] fill_m1;

  // index step with wrap at the queue depth
  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if ({1'b0, idx} == DEPTH_X - (IDX_W+1)'(1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  assign busy   = disp_r;
  assign accept = start && !disp_r;
  assign full   = !empty_r && (wrap_next(tail_r) == head_r);

  // words held minus one, tail inclusive
  always_comb begin
    if (tail_r >= head_r) begin
      span = {1'b0, tail_r} - {1'b0, head_r};
    end else begin
      span = {1'b0, tail_r} + DEPTH_X - {1'b0, head_r};
    end
  end
  assign fill_m1 = span[IDX_W-1:0];

  // command decode and pointer update
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    disp_nxt       = disp_r;
    ptr_nxt        = ptr_r;
    left_nxt       = left_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_last_nxt   = 1'b1;
    out_mem_nxt    = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    rd_en          = 1'b0;
    rd_addr        = head_r;

    if (disp_r) begin
      // display sweep: one stored word per cycle
      rd_en         = 1'b1;
      rd_addr       = ptr_r;
      out_valid_nxt = 1'b1;
      out_mem_nxt   = 1'b1;
      out_last_nxt  = (left_r == IDX_W'(1));
      ptr_nxt       = wrap_next(ptr_r);
      left_nxt      = left_r - IDX_W'(1);
      if (left_r == IDX_W'(1)) begin
        disp_nxt = 1'b0;
      end
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      if (in_item.func == OP_ENQ) begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = '0;
        end else begin
          tail_nxt = wrap_next(tail_r);
          wr_en    = 1'b1;
          wr_addr  = wrap_next(tail_r);
        end
      end else if (empty_r) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        rd_en       = 1'b1;
        out_mem_nxt = 1'b1;
        case (in_item.func)
          OP_DEQ: begin
            if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              head_nxt = wrap_next(head_r);
            end
          end
          OP_DISP: begin
            if (fill_m1 != '0) begin
              out_last_nxt = 1'b0;
              disp_nxt     = 1'b1;
              ptr_nxt      = wrap_next(head_r);
              left_nxt     = fill_m1;
            end
          end
          default: begin
            // peek leaves the pointers alone
          end
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      disp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      disp_r      <= disp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    left_r       <= left_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_mem_r    <= out_mem_nxt;
  end

  cqe_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result transaction
  assign out_valid = out_valid_r;
  always_comb begin
    out_item.status = out_status_r;
    out_item.data   = out_mem_r ? rd_data : '0;
    out_item.last   = out_last_r;
  end

`ifndef NO_ASSERTIONS
  // an empty queue sits at its reset position
  a_empty_home: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("empty queue with pointers away from zero");

  // every taken command yields a result in the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("command taken without a result");

  // results only come from a taken command or a display sweep
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept || disp_r))
    else $error("result with no cause");

  // a display sweep always has words left to show
  a_sweep_left: assert property (@(posedge clk) disable iff (!rst_n)
    disp_r |-> (left_r != '0) && !empty_r)
    else $error("display sweep with nothing left");

  // pointers stay inside the storage
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_r} < DEPTH_X) && ({1'b0, tail_r} < DEPTH_X))
    else $error("queue pointer beyond depth");
`endif

endmodule

>>> rtl/core/cqe_store.sv
// word storage of the queue: one write port, one registered read port
module cqe_store #(
  parameter int DEPTH = cqe_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [31:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [31:0]      rd_data
);
  import cqe_pkg::*;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
